// ===== design/l3dg_pkg.sv =====
// l3dg_pkg: shared constants, codes and types of the 3D LUT color grader.
// No dependencies; used by every module of the block but l3dg_ram.
package l3dg_pkg;

    localparam int MAX_GRID_POINTS_DEF = 33;
    localparam int ENTRY_FRAC_BITS_DEF = 12;

    localparam int PIX_W       = 8;
    localparam int ENTRY_W     = 16;
    localparam int INDEX_W     = 16;
    localparam int GRID_W      = 6;
    localparam int BLEND_W     = 9;
    localparam int BLEND_SHIFT = 8;
    localparam int FULL_SCALE  = 255;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 6'd33;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 9'd256;
    localparam logic [BLEND_W-1:0] BLEND_FULL  = 9'd256;

    typedef enum logic [0:0] {
        REG_GRID_POINTS    = 1'b0,
        REG_BLEND_STRENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    // Channel 0 red, 1 green, 2 blue.
    typedef logic [2:0][PIX_W-1:0]   rgb_t;
    typedef logic [2:0][ENTRY_W-1:0] entry_t;

endpackage

// ===== design/l3dg_ram.sv =====
// l3dg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module l3dg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/l3dg_blend.sv =====
// l3dg_blend: two-stage blend of one pixel channel with its table value.
// Depends on l3dg_pkg.
module l3dg_blend #(
    parameter int ENTRY_FRAC_BITS = l3dg_pkg::ENTRY_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [l3dg_pkg::PIX_W-1:0]          pix,
    input  logic signed [l3dg_pkg::ENTRY_W-1:0] lut,
    input  logic [l3dg_pkg::BLEND_W-1:0]        k,
    output logic [l3dg_pkg::PIX_W-1:0]          result
);

    localparam int SHIFT = ENTRY_FRAC_BITS + l3dg_pkg::BLEND_SHIFT;
    localparam int BASEW = ((ENTRY_FRAC_BITS + l3dg_pkg::PIX_W > 24) ?
                            ENTRY_FRAC_BITS + l3dg_pkg::PIX_W : 24);
    localparam int DW    = BASEW + 2;
    localparam int NW    = DW + l3dg_pkg::BLEND_W + 2;
    localparam int QW    = NW - SHIFT;

    logic signed [DW-1:0] lut_ext;
    logic signed [DW-1:0] p_sc;
    logic signed [DW-1:0] diff_next;
    logic signed [DW-1:0] diff_reg;
    logic [l3dg_pkg::PIX_W-1:0] pix_reg;
    logic signed [NW-1:0] prod;
    logic signed [NW-1:0] base;
    logic signed [NW-1:0] num_next;
    logic signed [NW-1:0] num_reg;
    logic [QW-1:0]        quot;

    assign lut_ext   = DW'(lut);
    assign p_sc      = $signed(DW'({pix, {ENTRY_FRAC_BITS{1'b0}}}));
    assign diff_next = (lut_ext <<< l3dg_pkg::PIX_W) - lut_ext - p_sc;

    assign prod     = diff_reg * $signed({1'b0, k});
    assign base     = $signed(NW'({pix_reg, {SHIFT{1'b0}}}));
    assign num_next = base + prod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            pix_reg  <= pix;
            num_reg  <= num_next;
        end
    end

    // Floor, then saturate to the byte range.
    assign quot = num_reg[NW-1:SHIFT];

    always_comb
    begin
        if (num_reg <= 0)
        begin
            result = '0;
        end
        else if (quot > QW'(l3dg_pkg::FULL_SCALE))
        begin
            result = l3dg_pkg::PIX_W'(l3dg_pkg::FULL_SCALE);
        end
        else
        begin
            result = quot[l3dg_pkg::PIX_W-1:0];
        end
    end

endmodule

// ===== design/lut3d_nearest_color_grade.sv =====
// lut3d_nearest_color_grade: nearest-point 3D color LUT with intensity blend.
// Depends on l3dg_pkg, l3dg_ram and l3dg_blend.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   item     | item_valid / item_stall    | command, red..blue, entry_* fields
//   result   | result_valid / result_stall| out_red, out_green, out_blue
//   config   | APB psel/penable/pready    | grid_points @0, blend_strength @4
//
// One item per clock unless a stalled result holds the pipe; the pixel result is registered at the output.
// Stages: grid coordinate, two index multiplies, table read, blend multiply.
// Reset clears table_ready and the pipe; table contents stay undefined, no sweep.
// A stalled result holds the whole pipe; item_stall rises only then.
module lut3d_nearest_color_grade #(
    parameter int MAX_GRID_POINTS = l3dg_pkg::MAX_GRID_POINTS_DEF,
    parameter int ENTRY_FRAC_BITS = l3dg_pkg::ENTRY_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [l3dg_pkg::PADDR_W-1:0]        paddr,
    input  logic [l3dg_pkg::PDATA_W-1:0]        pwdata,
    output logic [l3dg_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [l3dg_pkg::PIX_W-1:0]          red,
    input  logic [l3dg_pkg::PIX_W-1:0]          green,
    input  logic [l3dg_pkg::PIX_W-1:0]          blue,
    input  logic [l3dg_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [l3dg_pkg::ENTRY_W-1:0] entry_red,
    input  logic signed [l3dg_pkg::ENTRY_W-1:0] entry_green,
    input  logic signed [l3dg_pkg::ENTRY_W-1:0] entry_blue,
    input  logic                                entry_last,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [l3dg_pkg::PIX_W-1:0]          out_red,
    output logic [l3dg_pkg::PIX_W-1:0]          out_green,
    output logic [l3dg_pkg::PIX_W-1:0]          out_blue
);

    localparam int DEPTH = MAX_GRID_POINTS * MAX_GRID_POINTS * MAX_GRID_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_GRID_POINTS + 1);
    localparam int CW    = $clog2(MAX_GRID_POINTS);
    localparam int TW    = $clog2(MAX_GRID_POINTS * MAX_GRID_POINTS);
    localparam int XW    = l3dg_pkg::PIX_W + NW;
    localparam int RW    = ((NW > l3dg_pkg::PIX_W) ? NW : l3dg_pkg::PIX_W) + 1;
    localparam int CMPW  = (NW > l3dg_pkg::GRID_W) ? NW : l3dg_pkg::GRID_W;
    localparam int IW    = ((AW > l3dg_pkg::INDEX_W) ? AW : l3dg_pkg::INDEX_W) + 1;
    localparam int EW    = 3 * l3dg_pkg::ENTRY_W;

    // Configuration registers
    logic [l3dg_pkg::GRID_W-1:0]  grid_points_reg;
    logic [l3dg_pkg::BLEND_W-1:0] blend_strength_reg;
    logic                         cfg_wr;
    l3dg_pkg::reg_index_t         cfg_sel;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = l3dg_pkg::reg_index_t'(paddr[l3dg_pkg::PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_points_reg    <= l3dg_pkg::GRID_RESET;
            blend_strength_reg <= l3dg_pkg::BLEND_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                l3dg_pkg::REG_GRID_POINTS:
                begin
                    grid_points_reg <= pwdata[l3dg_pkg::GRID_W-1:0];
                end
                l3dg_pkg::REG_BLEND_STRENGTH:
                begin
                    blend_strength_reg <= pwdata[l3dg_pkg::BLEND_W-1:0];
                end
                default:
                begin
                    grid_points_reg <= grid_points_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            l3dg_pkg::REG_GRID_POINTS:    prdata = l3dg_pkg::PDATA_W'(grid_points_reg);
            l3dg_pkg::REG_BLEND_STRENGTH: prdata = l3dg_pkg::PDATA_W'(blend_strength_reg);
            default:                      prdata = '0;
        endcase
    end

    // Effective grid size and blend weight
    logic [CMPW-1:0]              gp_x;
    logic [NW-1:0]                n_eff;
    logic [NW-1:0]                nm1;
    logic [l3dg_pkg::BLEND_W-1:0] k_eff;

    assign gp_x = CMPW'(grid_points_reg);

    always_comb
    begin
        if (gp_x == '0)
        begin
            n_eff = NW'(1);
        end
        else if (gp_x > CMPW'(MAX_GRID_POINTS))
        begin
            n_eff = NW'(MAX_GRID_POINTS);
        end
        else
        begin
            n_eff = NW'(gp_x);
        end
    end

    assign nm1   = n_eff - NW'(1);
    assign k_eff = (blend_strength_reg > l3dg_pkg::BLEND_FULL) ?
                   l3dg_pkg::BLEND_FULL : blend_strength_reg;

    // Pipe control
    logic result_valid_reg;
    logic adv;
    logic accept;

    assign adv        = !result_valid_reg || !result_stall;
    assign item_stall = !adv;
    assign accept     = item_valid && adv;

    // Stage 1: grid coordinates, p*(n-1)/255 by compare and correct
    l3dg_pkg::rgb_t pix_in;
    logic [XW-1:0]  cx   [3];
    logic [NW-1:0]  cq0  [3];
    logic [RW-1:0]  cr0  [3];
    logic [NW-1:0]  cq   [3];
    logic [2:0][CW-1:0] coord_next;

    assign pix_in = {blue, green, red};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cx[c]  = XW'(pix_in[c]) * XW'(nm1);
            cq0[c] = cx[c][XW-1:l3dg_pkg::PIX_W];
            cr0[c] = RW'(cx[c][l3dg_pkg::PIX_W-1:0]) + RW'(cq0[c]);
            cq[c]  = cq0[c] + NW'(cr0[c] >= RW'(l3dg_pkg::FULL_SCALE));
            if (cq[c] > nm1)
            begin
                cq[c] = nm1;
            end
            coord_next[c] = CW'(cq[c]);
        end
    end

    logic                          s1_v_reg;
    logic                          s1_cmd_reg;
    l3dg_pkg::rgb_t                s1_pix_reg;
    logic [2:0][CW-1:0]            s1_coord_reg;
    logic [l3dg_pkg::INDEX_W-1:0]  s1_widx_reg;
    logic                          s1_wok_reg;
    l3dg_pkg::entry_t              s1_wdata_reg;
    logic                          s1_last_reg;
    logic                          wok_next;

    assign wok_next = IW'(entry_index) < IW'(DEPTH);

    // Stage 2: partial index b*n + g
    logic [TW-1:0]                 t_next;
    logic                          s2_v_reg;
    logic                          s2_cmd_reg;
    l3dg_pkg::rgb_t                s2_pix_reg;
    logic [CW-1:0]                 s2_cr_reg;
    logic [TW-1:0]                 s2_t_reg;
    logic [l3dg_pkg::INDEX_W-1:0]  s2_widx_reg;
    logic                          s2_wok_reg;
    l3dg_pkg::entry_t              s2_wdata_reg;
    logic                          s2_last_reg;

    assign t_next = TW'(TW'(s1_coord_reg[2]) * TW'(n_eff)) + TW'(s1_coord_reg[1]);

    // Stage 3: full index, table access, ready flag
    logic [AW-1:0]                 idx_next;
    logic                          s3_v_reg;
    logic                          s3_cmd_reg;
    l3dg_pkg::rgb_t                s3_pix_reg;
    logic [AW-1:0]                 s3_idx_reg;
    logic [l3dg_pkg::INDEX_W-1:0]  s3_widx_reg;
    logic                          s3_wok_reg;
    l3dg_pkg::entry_t              s3_wdata_reg;
    logic                          s3_last_reg;
    logic                          table_ready_reg;
    logic                          s3_write;
    logic                          ram_we;
    logic                          bypass_next;

    assign idx_next = AW'(AW'(s2_t_reg) * AW'(n_eff)) + AW'(s2_cr_reg);
    assign s3_write = s3_v_reg && (l3dg_pkg::command_t'(s3_cmd_reg) == l3dg_pkg::CMD_WRITE);
    assign ram_we   = adv && s3_write && s3_wok_reg;
    assign bypass_next = !table_ready_reg || (k_eff == '0);

    // Stage 4..6 control and payload
    logic             s4_v_reg, s5_v_reg, s6_v_reg;
    logic             s4_byp_reg, s5_byp_reg, s6_byp_reg;
    l3dg_pkg::rgb_t   s4_pix_reg, s5_pix_reg, s6_pix_reg;
    logic [EW-1:0]    ram_rdata;
    l3dg_pkg::entry_t lut_entry;
    l3dg_pkg::rgb_t   blended;
    l3dg_pkg::rgb_t   out_rgb_reg;

    assign lut_entry = l3dg_pkg::entry_t'(ram_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            s3_v_reg         <= 1'b0;
            s4_v_reg         <= 1'b0;
            s5_v_reg         <= 1'b0;
            s6_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            table_ready_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg         <= item_valid;
            s2_v_reg         <= s1_v_reg;
            s3_v_reg         <= s2_v_reg;
            s4_v_reg         <= s3_v_reg && !s3_write;
            s5_v_reg         <= s4_v_reg;
            s6_v_reg         <= s5_v_reg;
            result_valid_reg <= s6_v_reg;
            if (s3_write && s3_last_reg)
            begin
                table_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= command;
            s1_pix_reg   <= pix_in;
            s1_coord_reg <= coord_next;
            s1_widx_reg  <= entry_index;
            s1_wok_reg   <= wok_next;
            s1_wdata_reg <= {entry_blue, entry_green, entry_red};
            s1_last_reg  <= entry_last;
        end
        if (adv)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_cr_reg    <= s1_coord_reg[0];
            s2_t_reg     <= t_next;
            s2_widx_reg  <= s1_widx_reg;
            s2_wok_reg   <= s1_wok_reg;
            s2_wdata_reg <= s1_wdata_reg;
            s2_last_reg  <= s1_last_reg;

            s3_cmd_reg   <= s2_cmd_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_idx_reg   <= idx_next;
            s3_widx_reg  <= s2_widx_reg;
            s3_wok_reg   <= s2_wok_reg;
            s3_wdata_reg <= s2_wdata_reg;
            s3_last_reg  <= s2_last_reg;

            s4_byp_reg   <= bypass_next;
            s4_pix_reg   <= s3_pix_reg;
            s5_byp_reg   <= s4_byp_reg;
            s5_pix_reg   <= s4_pix_reg;
            s6_byp_reg   <= s5_byp_reg;
            s6_pix_reg   <= s5_pix_reg;

            if (s6_v_reg)
            begin
                out_rgb_reg <= s6_byp_reg ? s6_pix_reg : blended;
            end
        end
    end

    l3dg_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(s3_widx_reg)),
        .wdata (EW'(s3_wdata_reg)),
        .re    (adv),
        .raddr (s3_idx_reg),
        .rdata (ram_rdata)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_blend
        l3dg_blend #(
            .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
        ) u_blend (
            .clk    (clk),
            .en     (adv),
            .pix    (s4_pix_reg[c]),
            .lut    ($signed(lut_entry[c])),
            .k      (k_eff),
            .result (blended[c])
        );
    end

    assign result_valid = result_valid_reg;
    assign out_red      = out_rgb_reg[0];
    assign out_green    = out_rgb_reg[1];
    assign out_blue     = out_rgb_reg[2];

endmodule

// ===== design/l3dg_checker.sv =====
// l3dg_checker: port-level assertions for the 3D LUT color grader, bound to the top.
// Depends on l3dg_pkg and lut3d_nearest_color_grade.
module l3dg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic                         pready,
    input logic [l3dg_pkg::PADDR_W-1:0] paddr,
    input logic [l3dg_pkg::PDATA_W-1:0] pwdata,
    input logic [l3dg_pkg::PDATA_W-1:0] prdata,
    input logic                         item_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [l3dg_pkg::PIX_W-1:0]   out_red,
    input logic [l3dg_pkg::PIX_W-1:0]   out_green,
    input logic [l3dg_pkg::PIX_W-1:0]   out_blue
);

    // Input backpressure only from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item_stall without a stalled result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result beat dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            ($stable(out_red) && $stable(out_green) && $stable(out_blue)))
        else $error("result payload changed while stalled");

    // Grid size readback after a write
    a_grid_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         paddr[l3dg_pkg::PADDR_W-1] == l3dg_pkg::REG_GRID_POINTS) ##1
        (psel && !pwrite && paddr[l3dg_pkg::PADDR_W-1] == l3dg_pkg::REG_GRID_POINTS)
        |-> prdata[l3dg_pkg::GRID_W-1:0] == $past(pwdata[l3dg_pkg::GRID_W-1:0]))
        else $error("grid_points readback mismatch");

endmodule

bind lut3d_nearest_color_grade l3dg_checker u_l3dg_checker (.*);
